// File: rtl/plbe_pkg.sv
// Shared types, codes and character constants of the proof line byte encoder.
package plbe_pkg;

  localparam int unsigned NumW     = 64;
  localparam int unsigned RemW     = 16;
  localparam int unsigned DivCntW  = 7;
  localparam int unsigned Digits   = 20;
  localparam int unsigned BcdW     = Digits * 4;
  localparam int unsigned DigW     = 5;

  localparam logic [2:0] FuncAdd    = 3'd0;
  localparam logic [2:0] FuncDelete = 3'd1;
  localparam logic [2:0] FuncImport = 3'd2;
  localparam logic [2:0] FuncLit    = 3'd3;
  localparam logic [2:0] FuncEnd    = 3'd4;

  localparam logic [2:0] CfgBinary  = 3'd0;
  localparam logic [2:0] CfgIdMode  = 3'd1;
  localparam logic [2:0] CfgCount   = 3'd2;
  localparam logic [2:0] CfgIndex   = 3'd3;
  localparam logic [2:0] CfgOrig    = 3'd4;

  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] VarMore = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_PLAN, ST_ID_PREP, ST_ID_WAIT,
    ST_CONV, ST_PRE, ST_BODY, ST_SUF
  } state_e;

  typedef enum logic [1:0] { BODY_NONE, BODY_VAR, BODY_DEC } body_e;

  typedef enum logic [1:0] { PH_PRE, PH_BODY, PH_SUF } phase_e;

  typedef struct packed {
    logic   load_plan;
    logic   seed_start;
    logic   seed_fin;
    logic   id_prep;
    logic   id_fin;
    logic   conv_load;
    logic   conv_step;
    logic   emit;
    logic   adv;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    logic  plan_empty;
    logic  need_id;
    body_e body;
    logic  div_done;
    logic  conv_done;
    logic  cur_empty;
    logic  cur_skip;
    logic  cur_final;
    logic  cur_last;
    logic  out_free;
  } sts_t;

endpackage

// File: rtl/proof_line_byte_encoder.sv
// Top level of the proof line byte encoder: clause events in, proof file bytes out.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   func_i literal_i clause_id_i highest_import_id_i
//   out      source     out_valid_o/out_stall_i out_byte_o last_byte_o
//   cfg      sink       cfg_we_i                cfg_index_i cfg_data_i
//
// One item at a time. Each output byte leaves through the output register, after
// the plan step. Decimal fields first run a bit-serial binary-to-BCD shift and then
// give up to 20 digits; an added line in id mode first runs the
// bit-serial remainder of the id gap by solver_count.
// A write of original_clause_count runs the same remainder unit and
// holds in_stall_o high until the id counter is seeded.
// Reset sets the config registers to their defaults and clears the id counter and all control state.
// A stalled output beat holds; the controller waits on a full output register.
module proof_line_byte_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          func_i,
  input  logic signed [31:0]  literal_i,
  input  logic [62:0]         clause_id_i,
  input  logic [62:0]         highest_import_id_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_byte_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  plbe_pkg::cmd_t cmd;
  plbe_pkg::sts_t sts;
  logic           seed_req;

  // writing original_clause_count reseeds the id counter
  assign seed_req = cfg_we_i && (cfg_index_i == plbe_pkg::CfgOrig);

  plbe_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .seed_req_i (seed_req),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plbe_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .func_i              (func_i),
    .literal_i           (literal_i),
    .clause_id_i         (clause_id_i),
    .highest_import_id_i (highest_import_id_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .out_byte_o          (out_byte_o),
    .last_byte_o         (last_byte_o)
  );

endmodule

// File: rtl/plbe_mod.sv
// Iterative remainder unit: 64-bit dividend mod 16-bit divisor, one bit per cycle.
module plbe_mod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [plbe_pkg::NumW-1:0]      dividend_i,
  input  logic [plbe_pkg::RemW-1:0]      divisor_i,
  output logic                           done_o,
  output logic [plbe_pkg::RemW-1:0]      rem_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [plbe_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic [plbe_pkg::NumW-1:0]     dvd_q, dvd_d;
  logic [plbe_pkg::RemW-1:0]     dvs_q, dvs_d;
  logic [plbe_pkg::RemW-1:0]     rem_q, rem_d;
  logic [plbe_pkg::RemW:0]       trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[plbe_pkg::NumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = plbe_pkg::RemW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[plbe_pkg::RemW-1:0];
      end
      dvd_d = {dvd_q[plbe_pkg::NumW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == plbe_pkg::DivCntW'(plbe_pkg::NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/plbe_dp.sv
// Datapath: config registers, id counter, line plan, decimal and varint cursors, output register.
module plbe_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [2:0]          func_i,
  input  logic signed [31:0]  literal_i,
  input  logic [62:0]         clause_id_i,
  input  logic [62:0]         highest_import_id_i,
  input  plbe_pkg::cmd_t      cmd_i,
  output plbe_pkg::sts_t      sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                last_byte_o
);

  // configuration
  logic        bin_q;
  logic        idm_q;
  logic [15:0] cnt_q;
  logic [15:0] idx_q;
  logic [15:0] m_eff;

  // id counter and seeding
  logic [63:0] last_q, last_d;
  logic [63:0] s_q, s_d;
  logic [63:0] sum_q, sum_d;
  logic [31:0] c_q, c_d;
  logic [15:0] sidx_q, sidx_d;
  logic [15:0] m_q, m_d;
  logic [63:0] o_val;
  logic [63:0] id_val;
  logic [15:0] corr;

  // plan
  logic [7:0]  pre_q [2];
  logic [7:0]  suf_q [2];
  logic [7:0]  pre_d [2];
  logic [7:0]  suf_d [2];
  logic [1:0]  pre_n_q, pre_n_d, suf_n_q, suf_n_d;
  logic [1:0]  pre_i_q, pre_i_d, suf_i_q, suf_i_d;
  plbe_pkg::body_e body_q, body_d;
  logic        need_q, need_d;
  logic [63:0] num_q, num_d;

  // decimal conversion
  logic [plbe_pkg::BcdW-1:0]    bcd_q, bcd_d, bcd_adj;
  logic [plbe_pkg::DivCntW-1:0] conv_q, conv_d;
  logic [plbe_pkg::DigW-1:0]    dig_q, dig_d;
  logic                         started_q, started_d;
  logic [3:0]                   cur_digit;

  // literal
  logic        neg;
  logic [32:0] mag;

  // divider
  logic        div_start;
  logic [63:0] div_dvd;
  logic [15:0] div_dvs;
  logic        div_done;
  logic [15:0] div_rem;

  // output register
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d;
  logic [7:0]  cur_byte;
  logic        out_free;

  // cursor status
  logic        cur_empty;
  logic        cur_skip;
  logic        cur_final;
  logic        cur_last;

  assign m_eff = (cnt_q == 16'd0) ? 16'd1 : cnt_q;
  assign neg   = literal_i[31];
  assign mag   = neg ? (33'({1'b0, ~literal_i}) + 33'd1) : {1'b0, literal_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= 1'b0;
      idm_q <= 1'b0;
      cnt_q <= 16'd1;
      idx_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        plbe_pkg::CfgBinary: bin_q <= cfg_data_i[0];
        plbe_pkg::CfgIdMode: idm_q <= cfg_data_i[0];
        plbe_pkg::CfgCount:  cnt_q <= cfg_data_i[15:0];
        plbe_pkg::CfgIndex:  idx_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // divider operand selection
  assign o_val = s_q + 64'd1 - last_q;
  always_comb begin
    div_start = cmd_i.seed_start | cmd_i.id_prep;
    div_dvd   = cmd_i.seed_start ? {32'd0, cfg_data_i} : o_val;
    div_dvs   = m_eff;
  end

  plbe_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign corr   = (div_rem == 16'd0) ? 16'd0 : (m_q - div_rem);
  assign id_val = sum_q + {48'd0, corr};

  // decimal digit adjust (independent per digit)
  always_comb begin
    for (int i = 0; i < plbe_pkg::Digits; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  assign cur_digit = bcd_q[dig_q*4 +: 4];

  always_comb begin
    last_d    = last_q;
    s_d       = s_q;
    sum_d     = sum_q;
    c_d       = c_q;
    sidx_d    = sidx_q;
    m_d       = m_q;
    pre_d     = pre_q;
    suf_d     = suf_q;
    pre_n_d   = pre_n_q;
    suf_n_d   = suf_n_q;
    pre_i_d   = pre_i_q;
    suf_i_d   = suf_i_q;
    body_d    = body_q;
    need_d    = need_q;
    num_d     = num_q;
    bcd_d     = bcd_q;
    conv_d    = conv_q;
    dig_d     = dig_q;
    started_d = started_q;

    if (cmd_i.seed_start) begin
      c_d    = cfg_data_i;
      sidx_d = idx_q;
      m_d    = m_eff;
    end
    if (cmd_i.seed_fin) begin
      last_d = {32'd0, c_q} - {48'd0, div_rem} + {48'd0, sidx_q};
    end

    if (cmd_i.load_plan) begin
      s_d     = ({1'b0, highest_import_id_i} > last_q) ? {1'b0, highest_import_id_i} : last_q;
      pre_n_d = 2'd0;
      suf_n_d = 2'd0;
      pre_i_d = 2'd0;
      suf_i_d = 2'd0;
      body_d  = plbe_pkg::BODY_NONE;
      need_d  = 1'b0;
      pre_d[0] = plbe_pkg::ChSpace;
      pre_d[1] = plbe_pkg::ChSpace;
      suf_d[0] = plbe_pkg::ChSpace;
      suf_d[1] = plbe_pkg::ChSpace;
      case (func_i)
        plbe_pkg::FuncAdd: begin
          if (idm_q) begin
            need_d   = 1'b1;
            pre_d[0] = plbe_pkg::ChA;
            if (bin_q) begin
              pre_n_d = 2'd1;
              body_d  = plbe_pkg::BODY_VAR;
            end else begin
              pre_n_d = 2'd2;
              body_d  = plbe_pkg::BODY_DEC;
              suf_n_d = 2'd1;
            end
          end else if (bin_q) begin
            pre_d[0] = plbe_pkg::ChA;
            pre_n_d  = 2'd1;
          end
        end
        plbe_pkg::FuncDelete: begin
          pre_d[0] = plbe_pkg::ChD;
          pre_n_d  = bin_q ? 2'd1 : 2'd2;
        end
        plbe_pkg::FuncImport: begin
          pre_d[0] = plbe_pkg::ChI;
          if (bin_q) begin
            pre_n_d = 2'd1;
            body_d  = plbe_pkg::BODY_VAR;
            num_d   = {clause_id_i, 1'b0};
          end else begin
            pre_n_d = 2'd2;
            body_d  = plbe_pkg::BODY_DEC;
            num_d   = {1'b0, clause_id_i};
            suf_n_d = 2'd2;
          end
        end
        plbe_pkg::FuncLit: begin
          if (literal_i != 32'sd0) begin
            if (bin_q) begin
              body_d = plbe_pkg::BODY_VAR;
              num_d  = {30'd0, mag, neg};
            end else begin
              pre_d[0] = plbe_pkg::ChMinus;
              pre_n_d  = neg ? 2'd1 : 2'd0;
              body_d   = plbe_pkg::BODY_DEC;
              num_d    = {31'd0, mag};
              suf_n_d  = 2'd1;
            end
          end
        end
        plbe_pkg::FuncEnd: begin
          if (bin_q) begin
            pre_d[0] = plbe_pkg::ChNul;
            pre_n_d  = 2'd1;
          end else begin
            pre_d[0] = plbe_pkg::ChZero;
            pre_d[1] = plbe_pkg::ChNl;
            pre_n_d  = 2'd2;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.id_prep) begin
      sum_d = s_q + 64'd1;
      m_d   = m_eff;
    end
    if (cmd_i.id_fin) begin
      last_d = id_val;
      num_d  = bin_q ? {id_val[62:0], 1'b0} : id_val;
    end

    if (cmd_i.conv_load) begin
      bcd_d     = '0;
      conv_d    = '0;
      dig_d     = plbe_pkg::DigW'(plbe_pkg::Digits - 1);
      started_d = 1'b0;
    end
    if (cmd_i.conv_step) begin
      bcd_d  = {bcd_adj[plbe_pkg::BcdW-2:0], num_q[63]};
      num_d  = {num_q[62:0], 1'b0};
      conv_d = conv_q + 1'b1;
    end

    if (cmd_i.adv) begin
      case (cmd_i.phase)
        plbe_pkg::PH_PRE: pre_i_d = pre_i_q + 2'd1;
        plbe_pkg::PH_SUF: suf_i_d = suf_i_q + 2'd1;
        plbe_pkg::PH_BODY: begin
          if (body_q == plbe_pkg::BODY_VAR) begin
            num_d = {7'd0, num_q[63:7]};
          end else begin
            dig_d = dig_q - 1'b1;
            if (cmd_i.emit) begin
              started_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // current byte and its position in the item
  always_comb begin
    cur_byte  = plbe_pkg::ChNul;
    cur_empty = 1'b0;
    cur_skip  = 1'b0;
    cur_final = 1'b0;
    cur_last  = 1'b0;
    case (cmd_i.phase)
      plbe_pkg::PH_PRE: begin
        cur_byte  = pre_q[pre_i_q[0]];
        cur_empty = (pre_i_q == pre_n_q);
        cur_final = (pre_i_q == pre_n_q - 2'd1);
        cur_last  = cur_final && (body_q == plbe_pkg::BODY_NONE) && (suf_n_q == 2'd0);
      end
      plbe_pkg::PH_BODY: begin
        case (body_q)
          plbe_pkg::BODY_VAR: begin
            cur_final = (num_q[63:7] == 57'd0);
            cur_byte  = {1'b0, num_q[6:0]} | (cur_final ? 8'h00 : plbe_pkg::VarMore);
          end
          plbe_pkg::BODY_DEC: begin
            cur_final = (dig_q == '0);
            cur_skip  = !started_q && (cur_digit == 4'd0) && (dig_q != '0);
            cur_byte  = plbe_pkg::ChZero + {4'd0, cur_digit};
          end
          default: cur_empty = 1'b1;
        endcase
        cur_last = cur_final && (suf_n_q == 2'd0);
      end
      plbe_pkg::PH_SUF: begin
        cur_byte  = suf_q[suf_i_q[0]];
        cur_empty = (suf_i_q == suf_n_q);
        cur_final = (suf_i_q == suf_n_q - 2'd1);
        cur_last  = cur_final;
      end
      default: cur_empty = 1'b1;
    endcase
  end

  assign out_free = !ov_q || !out_stall_i;

  always_comb begin
    ov_d = ov_q;
    ob_d = ob_q;
    ol_d = ol_q;
    if (cmd_i.emit) begin
      ov_d = 1'b1;
      ob_d = cur_byte;
      ol_d = cur_last;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  assign sts_o.plan_empty = (pre_n_q == 2'd0) && (body_q == plbe_pkg::BODY_NONE) &&
                            (suf_n_q == 2'd0);
  assign sts_o.need_id    = need_q;
  assign sts_o.body       = body_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.conv_done  = (conv_q == plbe_pkg::DivCntW'(plbe_pkg::NumW));
  assign sts_o.cur_empty  = cur_empty;
  assign sts_o.cur_skip   = cur_skip;
  assign sts_o.cur_final  = cur_final;
  assign sts_o.cur_last   = cur_last;
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      ov_q      <= 1'b0;
      pre_n_q   <= 2'd0;
      suf_n_q   <= 2'd0;
      pre_i_q   <= 2'd0;
      suf_i_q   <= 2'd0;
      body_q    <= plbe_pkg::BODY_NONE;
      need_q    <= 1'b0;
      conv_q    <= '0;
      dig_q     <= '0;
      started_q <= 1'b0;
    end else begin
      last_q    <= last_d;
      ov_q      <= ov_d;
      pre_n_q   <= pre_n_d;
      suf_n_q   <= suf_n_d;
      pre_i_q   <= pre_i_d;
      suf_i_q   <= suf_i_d;
      body_q    <= body_d;
      need_q    <= need_d;
      conv_q    <= conv_d;
      dig_q     <= dig_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    sum_q  <= sum_d;
    c_q    <= c_d;
    sidx_q <= sidx_d;
    m_q    <= m_d;
    pre_q  <= pre_d;
    suf_q  <= suf_d;
    num_q  <= num_d;
    bcd_q  <= bcd_d;
    ob_q   <= ob_d;
    ol_q   <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign last_byte_o = ol_q;

endmodule

// File: rtl/plbe_ctl.sv
// Controller: sequences seeding, id update, decimal conversion and byte emission.
module plbe_ctl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            seed_req_i,
  input  plbe_pkg::sts_t  sts_i,
  output plbe_pkg::cmd_t  cmd_o
);

  plbe_pkg::state_e state_q, state_d;
  logic             idle;
  logic             send;

  assign idle = (state_q == plbe_pkg::ST_IDLE);
  assign send = !sts_i.cur_empty && !sts_i.cur_skip && sts_i.out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plbe_pkg::ST_IDLE: begin
        if (seed_req_i) begin
          state_d = plbe_pkg::ST_SEED;
        end else if (in_valid_i) begin
          state_d = plbe_pkg::ST_PLAN;
        end
      end
      plbe_pkg::ST_SEED: begin
        if (sts_i.div_done) state_d = plbe_pkg::ST_IDLE;
      end
      plbe_pkg::ST_PLAN: begin
        if (sts_i.plan_empty) begin
          state_d = plbe_pkg::ST_IDLE;
        end else if (sts_i.need_id) begin
          state_d = plbe_pkg::ST_ID_PREP;
        end else if (sts_i.body == plbe_pkg::BODY_DEC) begin
          state_d = plbe_pkg::ST_CONV;
        end else begin
          state_d = plbe_pkg::ST_PRE;
        end
      end
      plbe_pkg::ST_ID_PREP: state_d = plbe_pkg::ST_ID_WAIT;
      plbe_pkg::ST_ID_WAIT: begin
        if (sts_i.div_done) begin
          state_d = (sts_i.body == plbe_pkg::BODY_DEC) ? plbe_pkg::ST_CONV : plbe_pkg::ST_PRE;
        end
      end
      plbe_pkg::ST_CONV: begin
        if (sts_i.conv_done) state_d = plbe_pkg::ST_PRE;
      end
      plbe_pkg::ST_PRE, plbe_pkg::ST_BODY, plbe_pkg::ST_SUF: begin
        if (send && sts_i.cur_last) begin
          state_d = plbe_pkg::ST_IDLE;
        end else if (sts_i.cur_empty || (send && sts_i.cur_final)) begin
          case (state_q)
            plbe_pkg::ST_PRE:  state_d = plbe_pkg::ST_BODY;
            plbe_pkg::ST_BODY: state_d = plbe_pkg::ST_SUF;
            default:           state_d = plbe_pkg::ST_IDLE;
          endcase
        end
      end
      default: state_d = plbe_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.phase      = plbe_pkg::PH_PRE;
    in_stall_o       = !idle || seed_req_i;
    cmd_o.seed_start = idle && seed_req_i;
    cmd_o.load_plan  = idle && !seed_req_i && in_valid_i;
    case (state_q)
      plbe_pkg::ST_SEED:    cmd_o.seed_fin = sts_i.div_done;
      plbe_pkg::ST_PLAN: begin
        cmd_o.conv_load = !sts_i.plan_empty && !sts_i.need_id &&
                          (sts_i.body == plbe_pkg::BODY_DEC);
      end
      plbe_pkg::ST_ID_PREP: cmd_o.id_prep = 1'b1;
      plbe_pkg::ST_ID_WAIT: begin
        cmd_o.id_fin    = sts_i.div_done;
        cmd_o.conv_load = sts_i.div_done && (sts_i.body == plbe_pkg::BODY_DEC);
      end
      plbe_pkg::ST_CONV:    cmd_o.conv_step = !sts_i.conv_done;
      plbe_pkg::ST_PRE, plbe_pkg::ST_BODY, plbe_pkg::ST_SUF: begin
        case (state_q)
          plbe_pkg::ST_BODY: cmd_o.phase = plbe_pkg::PH_BODY;
          plbe_pkg::ST_SUF:  cmd_o.phase = plbe_pkg::PH_SUF;
          default:           cmd_o.phase = plbe_pkg::PH_PRE;
        endcase
        cmd_o.emit = send;
        cmd_o.adv  = send || (!sts_i.cur_empty && sts_i.cur_skip);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plbe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: dv/tb_proof_line_byte_encoder.sv
// Self-checking testbench for the proof line byte encoder: random clause events, byte stream check.
module tb_proof_line_byte_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte-stream scoreboard. It keeps its own copy of the config and id counter and
  // expands each accepted event into the bytes it must produce.
  class proof_byte_board;
    bit        bin_fmt;
    bit        id_on;
    bit [15:0] n_solvers;
    bit [15:0] my_index;
    bit [31:0] orig_count;
    bit [63:0] last_id;
    bit [7:0]  byte_q[$];
    bit        last_q[$];
    int        errors;

    function new();
      bin_fmt = 0; id_on = 0; n_solvers = 1; my_index = 0; orig_count = 0;
      last_id = 0; errors = 0;
    endfunction

    function bit [63:0] modv();
      return (n_solvers == 0) ? 64'd1 : {48'd0, n_solvers};
    endfunction

    function void seed_ids();
      bit [63:0] c;
      c = {32'd0, orig_count};
      last_id = c - (c % modv()) + {48'd0, my_index};
    endfunction

    function void write_reg(logic [2:0] idx, bit [31:0] v);
      case (idx)
        plbe_pkg::CfgBinary: bin_fmt = v[0];
        plbe_pkg::CfgIdMode: id_on = v[0];
        plbe_pkg::CfgCount:  n_solvers = v[15:0];
        plbe_pkg::CfgIndex:  my_index = v[15:0];
        plbe_pkg::CfgOrig:   begin orig_count = v; seed_ids(); end
        default: ;
      endcase
    endfunction

    function void push(bit [7:0] b);
      byte_q.push_back(b);
      last_q.push_back(1'b0);
    endfunction

    function void push_varint(bit [63:0] x);
      while (x > 64'h7f) begin
        push(x[7:0] | plbe_pkg::VarMore);
        x = x >> 7;
      end
      push(x[7:0]);
    endfunction

    function void push_dec(bit [63:0] x);
      bit [7:0] dig[$];
      do begin
        dig.push_front(plbe_pkg::ChZero + 8'(x % 10));
        x = x / 10;
      end while (x != 0);
      foreach (dig[k]) push(dig[k]);
    endfunction

    function bit [63:0] alloc_id(bit [62:0] high);
      bit [63:0] m, s, o, t;
      m = modv();
      s = ({1'b0, high} > last_id) ? {1'b0, high} : last_id;
      o = 64'd1 + s - last_id;
      t = m - (o % m);
      last_id = last_id + o + (t % m);
      return last_id;
    endfunction

    // note an accepted input beat
    function void note_item(logic [2:0] f, logic signed [31:0] lit,
                            bit [62:0] cid, bit [62:0] high);
      int start;
      bit [63:0] id, mag;
      start = byte_q.size();
      case (f)
        plbe_pkg::FuncAdd: begin
          if (id_on) begin
            id = alloc_id(high);
            push(plbe_pkg::ChA);
            if (bin_fmt) push_varint(id << 1);
            else begin push(plbe_pkg::ChSpace); push_dec(id); push(plbe_pkg::ChSpace); end
          end else if (bin_fmt) push(plbe_pkg::ChA);
        end
        plbe_pkg::FuncDelete: begin
          push(plbe_pkg::ChD);
          if (!bin_fmt) push(plbe_pkg::ChSpace);
        end
        plbe_pkg::FuncImport: begin
          push(plbe_pkg::ChI);
          if (bin_fmt) push_varint({cid, 1'b0});
          else begin
            push(plbe_pkg::ChSpace);
            push_dec({1'b0, cid});
            push(plbe_pkg::ChSpace);
            push(plbe_pkg::ChSpace);
          end
        end
        plbe_pkg::FuncLit: if (lit != 0) begin
          // magnitude taken in 64 bits so the most negative literal does not wrap
          mag = lit[31] ? (64'h1_0000_0000 - {32'd0, lit}) : {32'd0, lit};
          if (bin_fmt) push_varint(2 * mag + {63'd0, lit[31]});
          else begin
            if (lit[31]) push(plbe_pkg::ChMinus);
            push_dec(mag);
            push(plbe_pkg::ChSpace);
          end
        end
        plbe_pkg::FuncEnd: begin
          if (bin_fmt) push(plbe_pkg::ChNul);
          else begin push(plbe_pkg::ChZero); push(plbe_pkg::ChNl); end
        end
        default: ;
      endcase
      if (byte_q.size() > start) last_q[$] = 1'b1;
    endfunction

    // check one accepted output beat
    function void check_byte(bit [7:0] b, bit lb);
      bit [7:0] eb;
      bit el;
      if (byte_q.size() == 0) begin
        $error("unexpected byte 0x%02h", b);
        errors++;
        return;
      end
      eb = byte_q.pop_front();
      el = last_q.pop_front();
      if (eb !== b) begin
        $error("out_byte: expected 0x%02h, actual 0x%02h", eb, b);
        errors++;
      end
      if (el !== lb) begin
        $error("last_byte: expected %0d, actual %0d", el, lb);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  logic [2:0]        func_i = plbe_pkg::FuncEnd;
  logic signed [31:0] literal_i = 0;
  logic [62:0]       clause_id_i = 0;
  logic [62:0]       highest_import_id_i = 0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic [7:0]        out_byte_o;
  logic              last_byte_o;
  logic              cfg_we_i = 0;
  logic [2:0]        cfg_index_i = plbe_pkg::CfgBinary;
  logic [31:0]       cfg_data_i = 0;

  proof_line_byte_encoder dut (.*);

  always #4 clk_i = ~clk_i;

  proof_byte_board board = new();
  bit  hold_off_req = 0;   // set by stimulus to force one long receiver stall
  bit  stall_en = 1;
  int  idle_cycles = 0;
  localparam int WatchdogLimit = 20000;

  // output side: check at rising edge, choose next stall at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_byte(out_byte_o, last_byte_o);
  end

  // receiver stall pattern: quiet periods, choppy periods, and one long hold-off
  initial begin
    int mode;
    int len;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off_req = 0;
        out_stall_i <= 1'b0;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(5, 60);
      repeat (len) begin
        @(negedge clk_i);
        if (!stall_en || mode == 0) out_stall_i <= 1'b0;
        else if (mode == 1) out_stall_i <= ($urandom_range(0, 9) < 8);
        else out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog: cycles with no accepted beat on either side and no config write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // present one beat and wait until it is taken
  task automatic send_item(logic [2:0] f, logic signed [31:0] lit, bit [62:0] cid,
                           bit [62:0] high);
    func_i <= f;
    literal_i <= lit;
    clause_id_i <= cid;
    highest_import_id_i <= high;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(f, lit, cid, high);
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  // drain all expected bytes, then let a possibly byte-less item finish
  task automatic wait_drained();
    drop_valid();
    while (board.byte_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, bit [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    board.write_reg(idx, v);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit [62:0] rand_id();
    // mix of small ids and full-width ones
    case ($urandom_range(0, 3))
      0: return 63'($urandom_range(0, 20));
      1: return 63'($urandom());
      default: return 63'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic signed [31:0] rand_lit();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3: return $signed(32'($urandom()));
      default: return $signed(32'($urandom_range(0, 200))) - 100;
    endcase
  endfunction

  // a well-formed line with random content, sent with bursty gaps
  task automatic send_line();
    int nlit;
    send_item(3'($urandom_range(0, 2)), 0, rand_id(), rand_id());
    nlit = $urandom_range(0, 5);
    repeat (nlit) begin
      if ($urandom_range(0, 3) == 0) begin
        drop_valid();
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      send_item(plbe_pkg::FuncLit, rand_lit(), rand_id(), rand_id());
    end
    send_item(plbe_pkg::FuncEnd, 0, 0, 0);
  endtask

  task automatic random_phase(int n_items);
    int cnt;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: any func code including unused ones
        send_item(3'($urandom()), rand_lit(), rand_id(), rand_id());
        cnt++;
      end else begin
        send_line();
        cnt += 4;
      end
      if ($urandom_range(0, 2) == 0) begin
        drop_valid();
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: text mode, reset config
    stall_en = 0;
    send_item(plbe_pkg::FuncAdd, 0, 0, 0);
    send_item(plbe_pkg::FuncLit, 32'sh8000_0000, 0, 0);
    send_item(plbe_pkg::FuncLit, 32'sh7fff_ffff, 0, 0);
    send_item(plbe_pkg::FuncLit, 0, 0, 0);
    send_item(plbe_pkg::FuncLit, -1, 0, 0);
    send_item(plbe_pkg::FuncEnd, 0, 0, 0);
    send_item(plbe_pkg::FuncDelete, 0, 0, 0);
    send_item(plbe_pkg::FuncImport, 0, 63'h7fff_ffff_ffff_ffff, 0);
    send_item(plbe_pkg::FuncImport, 0, 0, 0);
    send_item(3'd5, 1, 1, 1);
    send_item(3'd7, 1, 1, 1);
    send_item(plbe_pkg::FuncEnd, 0, 0, 0);
    wait_drained();

    // directed: binary, id mode, zero solver count, huge highest id
    write_cfg(plbe_pkg::CfgBinary, 1);
    write_cfg(plbe_pkg::CfgIdMode, 1);
    write_cfg(plbe_pkg::CfgCount, 0);
    write_cfg(plbe_pkg::CfgIndex, 0);
    write_cfg(plbe_pkg::CfgOrig, 32'hffff_ffff);
    wait_drained();
    send_item(plbe_pkg::FuncAdd, 0, 0, 63'h7fff_ffff_ffff_ffff);
    send_item(plbe_pkg::FuncLit, 32'sh8000_0000, 0, 0);
    send_item(plbe_pkg::FuncLit, 32'sh7fff_ffff, 0, 0);
    send_item(plbe_pkg::FuncEnd, 0, 0, 0);
    send_item(plbe_pkg::FuncImport, 0, 63'h7fff_ffff_ffff_ffff, 0);
    send_item(plbe_pkg::FuncAdd, 0, 0, 0);
    send_item(plbe_pkg::FuncEnd, 0, 0, 0);
    wait_drained();
    stall_en = 1;

    // random phases over several settings, extremes included
    write_cfg(plbe_pkg::CfgCount, 32'h0000_ffff);
    write_cfg(plbe_pkg::CfgIndex, 32'h0000_fffe);
    write_cfg(plbe_pkg::CfgOrig, 32'h8000_1234);
    wait_drained();
    random_phase(40);
    wait_drained();

    write_cfg(plbe_pkg::CfgBinary, 0);
    write_cfg(plbe_pkg::CfgCount, 7);
    write_cfg(plbe_pkg::CfgIndex, 3);
    write_cfg(plbe_pkg::CfgOrig, 100);
    wait_drained();
    // long receiver hold-off while the sender keeps offering
    hold_off_req = 1;
    random_phase(40);
    wait_drained();

    write_cfg(plbe_pkg::CfgIdMode, 0);
    write_cfg(plbe_pkg::CfgBinary, 1);
    write_cfg(plbe_pkg::CfgCount, 1);
    write_cfg(plbe_pkg::CfgIndex, 0);
    write_cfg(plbe_pkg::CfgOrig, 0);
    wait_drained();
    random_phase(45);
    wait_drained();

    write_cfg(plbe_pkg::CfgIdMode, 1);
    write_cfg(plbe_pkg::CfgBinary, 0);
    write_cfg(plbe_pkg::CfgCount, 32'($urandom_range(1, 65535)));
    write_cfg(plbe_pkg::CfgIndex, 0);
    write_cfg(plbe_pkg::CfgOrig, $urandom());
    wait_drained();
    random_phase(45);
    wait_drained();

    if (board.errors == 0 && board.byte_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: proof_line_byte_encoder.f
rtl/plbe_pkg.sv
rtl/plbe_mod.sv
rtl/plbe_dp.sv
rtl/plbe_ctl.sv
rtl/proof_line_byte_encoder.sv
dv/tb_proof_line_byte_encoder.sv
